[design/pulse_peak_and_toa_extractor_assert.svh]
// Assertion macros used by the checker file of the extractor.
`ifndef PULSE_PEAK_AND_TOA_EXTRACTOR_ASSERT_SVH
`define PULSE_PEAK_AND_TOA_EXTRACTOR_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define PTE_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[design/pte_pkg.sv]
// ----------------------------------------------------------------------------
// pte_pkg
// Types and constants of the pulse peak and ToA extractor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pte_pkg;

  localparam int unsigned CHANNELS     = 152;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned CH_AW        = $clog2(CHANNELS);
  localparam int unsigned SMP_W        = 6;
  localparam int unsigned ADC_W        = 10;
  localparam int unsigned TOA_W        = 10;
  localparam int unsigned FINE_W       = 8;
  localparam int unsigned TIME_W       = 17;
  localparam int unsigned SAMPLE_UNITS = 1000;
  localparam int unsigned COARSE_UNITS = 250;

  // one detector sample as it enters
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] smp_idx;
    logic [ADC_W-1:0] adc_code;
    logic [TOA_W-1:0] toa_raw;
    logic [TOA_W-1:0] shift_thr;
    logic             last_sample;
  } sample_t;

  // per-channel state word
  typedef struct packed {
    logic [ADC_W-1:0] baseline;
    logic [ADC_W-1:0] peak;
    logic             seen;
    logic [SMP_W-1:0] toa_sample;
    logic [TOA_W-1:0] toa_code;
  } chan_state_t;

  localparam int unsigned STATE_W = $bits(chan_state_t);

  // state memory write port
  typedef struct packed {
    logic             en;
    logic [CH_AW-1:0] addr;
    chan_state_t      data;
  } ram_wr_t;

  // finished channel, waiting for time conversion
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [SMP_W-1:0] toa_sample;
    logic [TOA_W-1:0] toa_code;
    logic [TOA_W-1:0] shift_thr;
    logic [ADC_W-1:0] amplitude;
  } hit_t;

  // uncorrected time plus shift decision
  typedef struct packed {
    logic [CH_W-1:0]   channel;
    logic [TIME_W-1:0] raw_time;
    logic              shift;
    logic [ADC_W-1:0]  amplitude;
  } partial_t;

endpackage

[design/pte_ram.sv]
// ----------------------------------------------------------------------------
// pte_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pte_ram #(
  parameter int unsigned Depth = 152,
  parameter int unsigned Width = 37
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/pte_track.sv]
// ----------------------------------------------------------------------------
// pte_track
// Per-channel baseline / peak / first-ToA update with read-after-write bypass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pte_track (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 advance_i,
  input  logic                 in_valid_i,
  input  pte_pkg::sample_t     item_i,
  input  pte_pkg::chan_state_t rd_data_i,
  output pte_pkg::ram_wr_t     wr_o,
  output logic                 hit_valid_o,
  output pte_pkg::hit_t        hit_o
);

  import pte_pkg::*;

  logic        s1_valid_q;
  sample_t     s1_q;
  logic        byp_valid_q;
  logic [CH_AW-1:0] byp_addr_q;
  chan_state_t byp_data_q;
  logic        hit_valid_q;
  hit_t        hit_q;

  logic        in_range;
  logic [CH_AW-1:0] s1_addr;
  chan_state_t cur;
  chan_state_t nxt;
  logic        emit;
  hit_t        hit_d;

  assign in_range = {1'b0, item_i.channel} < (CH_W + 1)'(CHANNELS);
  assign s1_addr  = s1_q.channel[CH_AW-1:0];

  // the write made at the edge that launched our read is not in rd_data yet
  assign cur = (byp_valid_q && (byp_addr_q == s1_addr)) ? byp_data_q : rd_data_i;

  always_comb begin
    nxt = cur;
    if (s1_q.smp_idx == '0) begin
      nxt.baseline   = s1_q.adc_code;
      nxt.peak       = s1_q.adc_code;
      nxt.seen       = (s1_q.toa_raw != '0);
      nxt.toa_sample = '0;
      nxt.toa_code   = s1_q.toa_raw;
    end else begin
      if (s1_q.adc_code > cur.peak) begin
        nxt.peak = s1_q.adc_code;
      end
      if (!cur.seen && (s1_q.toa_raw != '0)) begin
        nxt.seen       = 1'b1;
        nxt.toa_sample = s1_q.smp_idx;
        nxt.toa_code   = s1_q.toa_raw;
      end
    end
  end

  assign emit = s1_valid_q && s1_q.last_sample && nxt.seen;

  always_comb begin
    hit_d.channel    = s1_q.channel;
    hit_d.toa_sample = nxt.toa_sample;
    hit_d.toa_code   = nxt.toa_code;
    hit_d.shift_thr  = s1_q.shift_thr;
    hit_d.amplitude  = nxt.peak - nxt.baseline;
  end

  assign wr_o.en   = advance_i && s1_valid_q;
  assign wr_o.addr = s1_addr;
  assign wr_o.data = nxt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      byp_valid_q <= 1'b0;
      hit_valid_q <= 1'b0;
    end else if (advance_i) begin
      s1_valid_q  <= in_valid_i && in_range;
      byp_valid_q <= s1_valid_q;
      hit_valid_q <= emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s1_q       <= item_i;
      byp_addr_q <= s1_addr;
      byp_data_q <= nxt;
      hit_q      <= hit_d;
    end
  end

  assign hit_valid_o = hit_valid_q;
  assign hit_o       = hit_q;

endmodule

[design/pte_timing.sv]
// ----------------------------------------------------------------------------
// pte_timing
// ToA code to 25 ps time: scale and threshold compare, then shift correction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pte_timing (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            advance_i,
  input  logic                            hit_valid_i,
  input  pte_pkg::hit_t                   hit_i,
  output logic                            out_valid_o,
  output logic [pte_pkg::CH_W-1:0]        out_channel_o,
  output logic signed [pte_pkg::TIME_W-1:0] toa_time_o,
  output logic [pte_pkg::ADC_W-1:0]       peak_amplitude_o
);

  import pte_pkg::*;

  localparam logic [TIME_W-1:0] SampleScale = TIME_W'(SAMPLE_UNITS);
  localparam logic [TIME_W-1:0] CoarseScale = TIME_W'(COARSE_UNITS);

  logic              s3_valid_q;
  partial_t          s3_q;
  partial_t          s3_d;
  logic              out_valid_q;
  logic [CH_W-1:0]   out_channel_q;
  logic [TIME_W-1:0] out_time_q;
  logic [TIME_W-1:0] out_time_d;
  logic [ADC_W-1:0]  out_amp_q;

  always_comb begin
    s3_d.channel   = hit_i.channel;
    s3_d.raw_time  = TIME_W'(hit_i.toa_sample) * SampleScale
                   + TIME_W'(hit_i.toa_code[TOA_W-1:FINE_W]) * CoarseScale
                   + TIME_W'(hit_i.toa_code[FINE_W-1:0]);
    s3_d.shift     = hit_i.toa_code > hit_i.shift_thr;
    s3_d.amplitude = hit_i.amplitude;
  end

  assign out_time_d = s3_q.shift ? (s3_q.raw_time - SampleScale) : s3_q.raw_time;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance_i) begin
      s3_valid_q  <= hit_valid_i;
      out_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      s3_q          <= s3_d;
      out_channel_q <= s3_q.channel;
      out_time_q    <= out_time_d;
      out_amp_q     <= s3_q.amplitude;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_channel_o    = out_channel_q;
  assign toa_time_o       = $signed(out_time_q);
  assign peak_amplitude_o = out_amp_q;

endmodule

[design/pulse_peak_and_toa_extractor.sv]
// ----------------------------------------------------------------------------
// pulse_peak_and_toa_extractor
// Per-channel pulse peak and first time-of-arrival extraction.
// ----------------------------------------------------------------------------
// Channel | Handshake           | Payload
// in      | in_valid/in_ready   | channel, smp_idx, adc_code, toa_raw,
//         |                     | shift_thr, last_sample
// out     | out_valid/out_ready | out_channel, toa_time, peak_amplitude
//
// One transaction is taken per clock, in any channel order, including the
// same channel back to back (a bypass covers the state RAM's registered
// read). A result passes the s1, s2, s3 and out registers before it is valid.
// All stages advance together; while a result sits unaccepted on the output
// the whole pipe holds and in_ready is low. Reset clears only the valid bits;
// the channel state RAM is undefined until a channel's sample 0 writes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_peak_and_toa_extractor (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [pte_pkg::CH_W-1:0]          channel_i,
  input  logic [pte_pkg::SMP_W-1:0]         smp_idx_i,
  input  logic [pte_pkg::ADC_W-1:0]         adc_code_i,
  input  logic [pte_pkg::TOA_W-1:0]         toa_raw_i,
  input  logic [pte_pkg::TOA_W-1:0]         shift_thr_i,
  input  logic                              last_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [pte_pkg::CH_W-1:0]          out_channel_o,
  output logic signed [pte_pkg::TIME_W-1:0] toa_time_o,
  output logic [pte_pkg::ADC_W-1:0]         peak_amplitude_o
);

  import pte_pkg::*;

  // Pipeline:
  //   s1  input register + state RAM read data
  //   s2  state update written back, finished channel captured (pte_track)
  //   s3  raw time = sample*1000 + coarse*250 + fine, threshold compare
  //   out shift correction, output register (pte_timing)
  logic        advance;
  logic        in_accept;
  sample_t     item;
  chan_state_t rd_data;
  logic [STATE_W-1:0] rd_raw;
  ram_wr_t     wr;
  logic        hit_valid;
  hit_t        hit;

  // a single global enable: everything moves unless the output is blocked
  assign advance    = !out_valid_o || out_ready_i;
  assign in_ready_o = advance;
  assign in_accept  = in_valid_i && advance;

  always_comb begin
    item.channel     = channel_i;
    item.smp_idx     = smp_idx_i;
    item.adc_code    = adc_code_i;
    item.toa_raw     = toa_raw_i;
    item.shift_thr   = shift_thr_i;
    item.last_sample = last_sample_i;
  end

  // state RAM read is issued on the accept edge, so data meets the item in s1
  pte_ram #(
    .Depth (CHANNELS),
    .Width (STATE_W)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (wr.en),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .re_i    (advance),
    .raddr_i (channel_i[CH_AW-1:0]),
    .rdata_o (rd_raw)
  );

  assign rd_data = chan_state_t'(rd_raw);

  pte_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .in_valid_i  (in_accept),
    .item_i      (item),
    .rd_data_i   (rd_data),
    .wr_o        (wr),
    .hit_valid_o (hit_valid),
    .hit_o       (hit)
  );

  pte_timing u_timing (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .advance_i        (advance),
    .hit_valid_i      (hit_valid),
    .hit_i            (hit),
    .out_valid_o      (out_valid_o),
    .out_channel_o    (out_channel_o),
    .toa_time_o       (toa_time_o),
    .peak_amplitude_o (peak_amplitude_o)
  );

endmodule

[design/pte_checker.sv]
// ----------------------------------------------------------------------------
// pte_checker
// Port-level checks of the extractor, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pulse_peak_and_toa_extractor_assert.svh"

module pte_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [pte_pkg::CH_W-1:0]          out_channel_o,
  input logic signed [pte_pkg::TIME_W-1:0] toa_time_o,
  input logic [pte_pkg::ADC_W-1:0]         peak_amplitude_o
);

  import pte_pkg::*;

  `PTE_ASSERT(a_out_hold, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_channel_o) &&
    $stable(toa_time_o) && $stable(peak_amplitude_o),
    "result changed while stalled")

  `PTE_ASSERT(a_ready_tracks_out, clk_i, rst_ni,
    in_ready_o == (!out_valid_o || out_ready_i),
    "input stalled without a blocked result")

  `PTE_ASSERT(a_channel_range, clk_i, rst_ni,
    out_valid_o |-> ({1'b0, out_channel_o} < (CH_W + 1)'(CHANNELS)),
    "result for a nonexistent channel")

  `PTE_ASSERT(a_time_range, clk_i, rst_ni,
    out_valid_o |-> (toa_time_o >= -17'sd1000) && (toa_time_o <= 17'sd64005),
    "ToA time out of range")

  `PTE_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |=> !out_valid_o, "result during reset")

endmodule

bind pulse_peak_and_toa_extractor pte_checker u_pte_checker (.*);
